// ===== rtl/pinned_code_variant_matcher_assert.svh =====
// assertion macros for the pinned code variant matcher
`ifndef PINNED_CODE_VARIANT_MATCHER_ASSERT_SVH
`define PINNED_CODE_VARIANT_MATCHER_ASSERT_SVH

// same-cycle implication
`define PCVM_AST_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PCVM_AST_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/pcvm_pkg.sv =====
package pcvm_pkg;

    localparam int ENTRIES_DEF   = 16;
    localparam int MAX_WORDS_DEF = 256;

    localparam logic [63:0] FNV_BASIS       = 64'hcbf29ce484222325;
    // prime is 2^40 + 0x1b3
    localparam logic [8:0]  FNV_PRIME_LO    = 9'h1b3;
    localparam int          FNV_PRIME_SHIFT = 40;

    localparam logic [7:0]  DYN_LIMIT = 8'd1;
    localparam logic [15:0] MAP_LIMIT = 16'd256;

    localparam logic [1:0] OP_REGISTER = 2'd0;
    localparam logic [1:0] OP_EXACT    = 2'd1;
    localparam logic [1:0] OP_LEGACY   = 2'd2;
    localparam logic [1:0] OP_VARIANT  = 2'd3;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NO_MATCH = 3'd1;
    localparam logic [2:0] ST_BAD_SIG  = 3'd2;
    localparam logic [2:0] ST_BAD_MAP  = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] code_word;
        logic        final_word;
        logic [31:0] kind_key;
        logic [31:0] origin_key;
        logic [63:0] variant_tag;
        logic [15:0] needed_mask;
        logic [8:0]  claimed_count;
        logic [63:0] claimed_digest;
        logic        payload_present;
        logic [7:0]  dynamic_flag;
        logic [15:0] constant_total;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  entry_index;
        logic [63:0] entry_variant;
        logic [63:0] call_digest;
        logic [4:0]  entry_total;
    } t_out;

    typedef struct packed {
        logic load;
        logic mix;
        logic mul;
        logic add;
        logic scan_step;
        logic pos_adv;
        logic walk_init;
        logic walk_step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic       scan_done;
        logic       walk_done;
        logic       final_word;
        logic [1:0] op;
    } t_stat;

endpackage

// ===== rtl/pcvm_ram.sv =====
module pcvm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/pcvm_ctrl.sv =====
module pcvm_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  pcvm_pkg::t_stat i_stat,
    output pcvm_pkg::t_cmd  o_cmd
);
    import pcvm_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_MIX    = 4'd1;
    localparam logic [3:0] S_MUL    = 4'd2;
    localparam logic [3:0] S_ADD    = 4'd3;
    localparam logic [3:0] S_SCAN   = 4'd4;
    localparam logic [3:0] S_SDRAIN = 4'd5;
    localparam logic [3:0] S_WALK   = 4'd6;
    localparam logic [3:0] S_WDRAIN = 4'd7;
    localparam logic [3:0] S_DONE   = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;
    t_cmd       w_cmd;

    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    w_cmd.load = 1'b1;
                    n_state    = S_MIX;
                end
            end
            S_MIX: begin
                w_cmd.mix = 1'b1;
                n_state   = S_MUL;
            end
            S_MUL: begin
                w_cmd.mul = 1'b1;
                n_state   = S_ADD;
            end
            S_ADD: begin
                w_cmd.add = 1'b1;
                n_state   = S_SCAN;
            end
            S_SCAN: begin
                if (i_stat.scan_done) begin
                    n_state = S_SDRAIN;
                end else begin
                    w_cmd.scan_step = 1'b1;
                end
            end
            S_SDRAIN: begin
                w_cmd.pos_adv = 1'b1;
                if (!i_stat.final_word) begin
                    n_state = S_IDLE;
                end else if (i_stat.op == OP_REGISTER) begin
                    n_state = S_DONE;
                end else begin
                    w_cmd.walk_init = 1'b1;
                    n_state         = S_WALK;
                end
            end
            S_WALK: begin
                if (i_stat.walk_done) begin
                    n_state = S_WDRAIN;
                end else begin
                    w_cmd.walk_step = 1'b1;
                end
            end
            S_WDRAIN: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                w_cmd.finish = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy  = (r_state != S_IDLE);
    assign o_cmd = w_cmd;
endmodule

// ===== rtl/pcvm_dp.sv =====
module pcvm_dp #(
    parameter int ENTRIES   = 16,
    parameter int MAX_WORDS = 256
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  pcvm_pkg::t_in   i_item,
    input  pcvm_pkg::t_cmd  i_cmd,
    output pcvm_pkg::t_stat o_stat,
    output logic            o_done,
    output pcvm_pkg::t_out  o_res
);
    import pcvm_pkg::*;

    localparam int EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int FW = $clog2(ENTRIES + 1);
    localparam int PW = $clog2(MAX_WORDS + 2);
    localparam int WD = ENTRIES * MAX_WORDS;
    localparam int AW = (WD > 1) ? $clog2(WD) : 1;
    localparam int BW = AW + 1;
    localparam int KW = 32 + 32 + PW + 64 + 64;
    localparam int CW = (PW > 9) ? PW : 9;

    t_in           r_item;
    logic [63:0]   r_dig, r_x, r_t;
    logic [PW-1:0] r_pos;
    logic [ENTRIES-1:0] r_eq;
    logic [FW-1:0] r_filled;
    logic [BW-1:0] r_fbase, r_base;
    logic [FW-1:0] r_e;
    logic          r_rd_v, r_rd_walk;
    logic [EW-1:0] r_rd_e;
    logic          r_f1, r_fa;
    logic [EW-1:0] r_i1, r_ia;
    logic [63:0]   r_v1, r_va;
    logic [4:0]    r_best;
    logic          r_done;
    t_out          r_res;

    logic          w_pos_lt, w_filled_lt;
    logic [BW-1:0] w_waddr, w_raddr;
    logic [31:0]   w_wrd;
    logic [KW-1:0] w_kwd, w_krd;
    logic [31:0]   w_kd_kind, w_kd_origin;
    logic [PW-1:0] w_kd_len;
    logic [63:0]   w_kd_dig, w_kd_var, w_want;
    logic [4:0]    w_pc;
    logic          w_match, w_var_ok, w_upd1, w_upda;
    logic          w_bad_sig, w_commit, w_found;
    t_out          n_res;

    assign w_pos_lt    = r_pos < PW'(MAX_WORDS);
    assign w_filled_lt = r_filled < FW'(ENTRIES);
    assign w_waddr     = r_fbase + BW'(r_pos);
    assign w_raddr     = r_base + BW'(r_pos);

    // MAX_WORDS words per entry slot, entries laid out back to back
    pcvm_ram #(.WIDTH(32), .DEPTH(WD), .AW(AW)) u_words (
        .i_clk  (i_clk),
        .i_we   (i_cmd.load && w_pos_lt && w_filled_lt),
        .i_waddr(w_waddr[AW-1:0]),
        .i_wdata(i_item.code_word),
        .i_re   (i_cmd.scan_step),
        .i_raddr(w_raddr[AW-1:0]),
        .o_rdata(w_wrd)
    );

    assign w_kwd = {r_item.kind_key, r_item.origin_key, r_pos, r_dig, r_item.variant_tag};

    pcvm_ram #(.WIDTH(KW), .DEPTH(ENTRIES), .AW(EW)) u_keys (
        .i_clk  (i_clk),
        .i_we   (w_commit),
        .i_waddr(r_filled[EW-1:0]),
        .i_wdata(w_kwd),
        .i_re   (i_cmd.walk_step),
        .i_raddr(r_e[EW-1:0]),
        .o_rdata(w_krd)
    );

    assign w_kd_kind   = w_krd[KW-1 -: 32];
    assign w_kd_origin = w_krd[KW-33 -: 32];
    assign w_kd_len    = w_krd[128 +: PW];
    assign w_kd_dig    = w_krd[64 +: 64];
    assign w_kd_var    = w_krd[63:0];

    // entry evaluation during the table walk
    always_comb begin
        w_match = (w_kd_kind == r_item.kind_key) && (w_kd_origin == r_item.origin_key)
            && (w_kd_len == r_pos) && (w_kd_dig == r_dig) && r_eq[r_rd_e];
        w_want  = (r_item.operation == OP_EXACT) ? r_item.variant_tag : 64'd0;
        w_pc    = 5'($countones(w_kd_var[15:0]));
        w_var_ok = w_match && (w_kd_var[63:32] == r_item.variant_tag[63:32])
            && ((w_kd_var[15:0] & r_item.needed_mask) == r_item.needed_mask);
        if (r_item.operation == OP_VARIANT) begin
            w_upd1 = w_var_ok && (!r_f1 || (w_pc < r_best));
        end else begin
            w_upd1 = w_match && (w_kd_var == w_want) && !r_f1;
        end
        w_upda = w_match && !r_fa;
    end

    // result of the call
    always_comb begin
        w_bad_sig = (r_pos > PW'(MAX_WORDS)) || (CW'(r_item.claimed_count) != CW'(r_pos))
            || (r_item.claimed_digest != r_dig);
        w_commit  = 1'b0;
        w_found   = r_f1 || ((r_item.operation == OP_LEGACY) && r_fa);
        n_res     = '0;
        n_res.call_digest = r_dig;
        n_res.entry_total = 5'(r_filled);
        if (r_item.operation == OP_REGISTER) begin
            priority if (!r_item.payload_present) begin
                n_res.status = ST_BAD_MAP;
            end else if (w_bad_sig) begin
                n_res.status = ST_BAD_SIG;
            end else if ((r_item.dynamic_flag > DYN_LIMIT)
                         || (r_item.constant_total > MAP_LIMIT)) begin
                n_res.status = ST_BAD_MAP;
            end else if (!w_filled_lt) begin
                n_res.status = ST_FULL;
            end else begin
                w_commit            = i_cmd.finish;
                n_res.status        = ST_OK;
                n_res.entry_index   = 4'(r_filled);
                n_res.entry_variant = r_item.variant_tag;
                n_res.entry_total   = 5'(r_filled + FW'(1));
            end
        end else if (w_found) begin
            n_res.status        = ST_OK;
            n_res.entry_index   = r_f1 ? 4'(r_i1) : 4'(r_ia);
            n_res.entry_variant = r_f1 ? r_v1 : r_va;
        end else begin
            n_res.status = ST_NO_MATCH;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dig    <= FNV_BASIS;
            r_pos    <= '0;
            r_eq     <= '1;
            r_filled <= '0;
            r_fbase  <= '0;
            r_e      <= '0;
            r_rd_v   <= 1'b0;
            r_f1     <= 1'b0;
            r_fa     <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_done <= i_cmd.finish;
            r_rd_v <= i_cmd.scan_step | i_cmd.walk_step;
            if (i_cmd.load || i_cmd.walk_init) begin
                r_e <= '0;
            end else if (i_cmd.scan_step || i_cmd.walk_step) begin
                r_e <= r_e + FW'(1);
            end
            if (i_cmd.add) begin
                r_dig <= r_t + (r_x << FNV_PRIME_SHIFT);
            end
            if (r_rd_v && !r_rd_walk && (w_wrd != r_item.code_word)) begin
                r_eq[r_rd_e] <= 1'b0;
            end
            if (i_cmd.pos_adv && (r_pos <= PW'(MAX_WORDS))) begin
                r_pos <= r_pos + PW'(1);
            end
            if (i_cmd.walk_init) begin
                r_f1 <= 1'b0;
                r_fa <= 1'b0;
            end else if (r_rd_v && r_rd_walk) begin
                if (w_upd1) begin
                    r_f1 <= 1'b1;
                end
                if (w_upda) begin
                    r_fa <= 1'b1;
                end
            end
            if (i_cmd.finish) begin
                r_dig <= FNV_BASIS;
                r_pos <= '0;
                r_eq  <= '1;
                if (w_commit) begin
                    r_filled <= r_filled + FW'(1);
                    r_fbase  <= r_fbase + BW'(MAX_WORDS);
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_rd_walk <= i_cmd.walk_step;
        r_rd_e    <= r_e[EW-1:0];
        if (i_cmd.load) begin
            r_item <= i_item;
            r_base <= '0;
        end else if (i_cmd.scan_step) begin
            r_base <= r_base + BW'(MAX_WORDS);
        end
        if (i_cmd.mix) begin
            r_x <= r_dig ^ {32'd0, r_item.code_word};
        end
        if (i_cmd.mul) begin
            r_t <= r_x * FNV_PRIME_LO;
        end
        if (r_rd_v && r_rd_walk) begin
            if (w_upd1) begin
                r_i1   <= r_rd_e;
                r_v1   <= w_kd_var;
                r_best <= w_pc;
            end
            if (w_upda) begin
                r_ia <= r_rd_e;
                r_va <= w_kd_var;
            end
        end
        if (i_cmd.finish) begin
            r_res <= n_res;
        end
    end

    assign o_stat.scan_done  = (r_e >= r_filled) || !w_pos_lt;
    assign o_stat.walk_done  = (r_e >= r_filled);
    assign o_stat.final_word = r_item.final_word;
    assign o_stat.op         = r_item.operation;
    assign o_done            = r_done;
    assign o_res             = r_res;
endmodule

// ===== rtl/pinned_code_variant_matcher.sv =====
// pinned code variant matcher
// a call streams its 32-bit code words one word at a time on i_item, with
// final_word set on the last one; that last word also carries the operation
// (register, exact, legacy or variant lookup), the keys and the check fields
// a word is taken when start is high and busy is low
// each word runs the fnv-1a-64 update in three steps (xor, multiply by the low
// prime part, add of the shifted term) and a walk that reads the word store
// once per stored entry through its single read port
// on the last word a registration then finishes, while a lookup first makes a
// second walk over the key table, one entry per cycle, before it finishes
// the result word appears on o_res with o_done high for exactly one cycle,
// in the first cycle with busy low; the receiver cannot stall it, so it must
// take the word then
// reset (synchronous, active low) empties the table and clears the call state;
// the stores need no clearing pass, entries are tracked by a fill count
module pinned_code_variant_matcher #(
    parameter int ENTRIES   = pcvm_pkg::ENTRIES_DEF,
    parameter int MAX_WORDS = pcvm_pkg::MAX_WORDS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  pcvm_pkg::t_in  i_item,
    output logic           o_done,
    output pcvm_pkg::t_out o_res
);
    import pcvm_pkg::*;

    // command and status between sequencer and datapath
    t_cmd  w_cmd;
    t_stat w_stat;

    pcvm_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .busy   (busy),
        .i_stat (w_stat),
        .o_cmd  (w_cmd)
    );

    // digest, word store, key table and entry selection
    pcvm_dp #(
        .ENTRIES  (ENTRIES),
        .MAX_WORDS(MAX_WORDS)
    ) u_dp (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_item (i_item),
        .i_cmd  (w_cmd),
        .o_stat (w_stat),
        .o_done (o_done),
        .o_res  (o_res)
    );
endmodule

// ===== rtl/pcvm_chk.sv =====
`include "pinned_code_variant_matcher_assert.svh"

module pcvm_chk (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           start,
    input logic           busy,
    input pcvm_pkg::t_in  i_item,
    input logic           o_done,
    input pcvm_pkg::t_out o_res
);
    import pcvm_pkg::*;

    `PCVM_AST_NXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy, "busy missing after accept")
    `PCVM_AST_IMP(a_done_idle, i_clk, i_rst_n, o_done, !busy && !i_item.final_word || !busy, "result while busy")
    `PCVM_AST_NXT(a_done_single, i_clk, i_rst_n, o_done, !o_done, "result strobe repeated")
    `PCVM_AST_IMP(a_miss_zero, i_clk, i_rst_n, o_done && (o_res.status != ST_OK), (o_res.entry_index == 4'd0) && (o_res.entry_variant == 64'd0), "failed call reports an entry")
endmodule

bind pinned_code_variant_matcher pcvm_chk u_pcvm_chk (
    .i_clk  (i_clk),
    .i_rst_n(i_rst_n),
    .start  (start),
    .busy   (busy),
    .i_item (i_item),
    .o_done (o_done),
    .o_res  (o_res)
);
